@@ rtl/rwhp_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RIFF/WAVE header parser package
// Shared payload types, magic words and status codes.
// ----------------------------------------------------------------------------
package rwhp_pkg;

   localparam int OFFSET_BITS_DEFAULT = 32;

   // Little-endian tag words as they appear in the shift register.
   localparam logic [31:0] MAGIC_RIFF = 32'h4646_4952;
   localparam logic [31:0] MAGIC_WAVE = 32'h4556_4157;
   localparam logic [31:0] MAGIC_FMT  = 32'h2074_6d66;
   localparam logic [31:0] MAGIC_DATA = 32'h6174_6164;

   localparam logic [3:0] ST_OK        = 4'd0;
   localparam logic [3:0] ST_BAD_RIFF  = 4'd1;
   localparam logic [3:0] ST_BAD_WAVE  = 4'd2;
   localparam logic [3:0] ST_EMPTY     = 4'd3;
   localparam logic [3:0] ST_SHORT_FMT = 4'd4;
   localparam logic [3:0] ST_NO_FMT    = 4'd5;
   localparam logic [3:0] ST_NO_DATA   = 4'd6;
   localparam logic [3:0] ST_TRUNC     = 4'd7;
   localparam logic [3:0] ST_BAD_TAG   = 4'd8;
   localparam logic [3:0] ST_BAD_CH    = 4'd9;
   localparam logic [3:0] ST_BAD_BITS  = 4'd10;

   typedef struct packed {
      logic [7:0] byte_in;
      logic       last_byte;
   } rwhp_req_type;

   typedef struct packed {
      logic [3:0]  status;
      logic [1:0]  sample_format;
      logic [31:0] sample_rate;
      logic [31:0] data_offset;
      logic [31:0] data_length;
   } rwhp_rsp_type;

endpackage

@@ rtl/rwhp_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RIFF/WAVE parser front end
// Accepts bytes, keeps the byte position and the 32-bit little-endian shift
// word, and hands each byte on to the queue already positioned.
// ----------------------------------------------------------------------------
module rwhp_front #(
   parameter int OFFSET_BITS = rwhp_pkg::OFFSET_BITS_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  rwhp_pkg::rwhp_req_type    req_data,
   output logic                      push_valid,
   input  logic                      push_ready,
   output logic [OFFSET_BITS+33:0]   push_data
);

   typedef struct packed {
      logic [OFFSET_BITS-1:0] pos;
      logic                   parse_en;
      logic [31:0]            shift_word;
      logic                   last;
   } entry_type;

   logic [OFFSET_BITS-1:0] pos_ff, pos_in;
   logic [31:0]            shift_ff, shift_in;
   logic                   parse_en;
   logic                   accept;
   entry_type              entry;

   assign req_ready  = push_ready;
   assign push_valid = req_valid;
   assign accept     = req_valid && push_ready;

   // Once the position counter reaches all ones, further bytes are passed on unparsed.
   assign parse_en = (pos_ff != {OFFSET_BITS{1'b1}});

   always_comb begin
      entry.pos        = pos_ff;
      entry.parse_en   = parse_en;
      entry.shift_word = parse_en ? {req_data.byte_in, shift_ff[31:8]} : shift_ff;
      entry.last       = req_data.last_byte;
      push_data        = entry;
      pos_in           = pos_ff;
      shift_in         = shift_ff;
      if (accept) begin
         if (req_data.last_byte) begin
            pos_in   = '0;
            shift_in = '0;
         end else begin
            pos_in   = parse_en ? pos_ff + 1'b1 : pos_ff;
            shift_in = entry.shift_word;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff   <= '0;
         shift_ff <= '0;
      end else begin
         pos_ff   <= pos_in;
         shift_ff <= shift_in;
      end
   end

endmodule

@@ rtl/rwhp_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RIFF/WAVE parser decoupling queue
// Two-entry FIFO between the front end and the chunk walker.
// ----------------------------------------------------------------------------
module rwhp_queue #(
   parameter int WIDTH = 66
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   output logic             push_ready,
   input  logic [WIDTH-1:0] push_data,
   output logic             pop_valid,
   input  logic             pop_ready,
   output logic [WIDTH-1:0] pop_data
);

   logic [WIDTH-1:0] slot_ff [2];
   logic             wr_ptr_ff, wr_ptr_in;
   logic             rd_ptr_ff, rd_ptr_in;
   logic [1:0]       count_ff, count_in;
   logic             push, pop;

   assign push_ready = (count_ff != 2'd2);
   assign pop_valid  = (count_ff != 2'd0);
   assign pop_data   = slot_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

@@ rtl/rwhp_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RIFF/WAVE parser chunk walker
// Checks the file header, walks the chunk list, latches the fmt and data
// fields and builds the result transaction on the final byte.
// ----------------------------------------------------------------------------
module rwhp_back #(
   parameter int OFFSET_BITS = rwhp_pkg::OFFSET_BITS_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      pop_valid,
   output logic                      pop_ready,
   input  logic [OFFSET_BITS+33:0]   pop_data,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output rwhp_pkg::rwhp_rsp_type    rsp_data
);

   typedef struct packed {
      logic [OFFSET_BITS-1:0] pos;
      logic                   parse_en;
      logic [31:0]            shift_word;
      logic                   last;
   } entry_type;

   entry_type              entry;
   logic                   pop;
   logic [OFFSET_BITS-1:0] pos_plus1;
   logic [OFFSET_BITS-1:0] pos_final;
   logic                   hdr_start;
   logic [OFFSET_BITS-1:0] hdr_base;
   logic [OFFSET_BITS-1:0] hdr_rel;
   logic [OFFSET_BITS-1:0] body_rel;
   logic [32:0]            end_sum;
   logic [31:0]            hs;
   logic [3:0]             status;
   logic [1:0]             sample_format;

   logic [31:0]            riff_ff, riff_in;
   logic [32:0]            ncs_ff, ncs_in;
   logic [31:0]            tag_ff, tag_in;
   logic [15:0]            fmt_tag_ff, fmt_tag_in;
   logic [15:0]            chan_ff, chan_in;
   logic [31:0]            rate_ff, rate_in;
   logic [15:0]            bits_ff, bits_in;
   logic [1:0]             seen_ff, seen_in;
   logic [31:0]            dstart_ff, dstart_in;
   logic [31:0]            dlen_ff, dlen_in;
   logic [3:0]             err_ff, err_in;
   logic                   in_hdr_ff, in_hdr_in;
   logic [OFFSET_BITS-1:0] base_ff, base_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   rwhp_pkg::rwhp_rsp_type rsp_ff, rsp_in;

   assign entry     = pop_data;
   assign hs        = entry.shift_word;
   // A non-final byte never waits on the output register.
   assign pop_ready = !entry.last || !rsp_valid_ff || rsp_ready;
   assign pop       = pop_valid && pop_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   assign pos_plus1 = entry.pos + 1'b1;
   assign pos_final = entry.parse_en ? pos_plus1 : entry.pos;
   assign hdr_start = !in_hdr_ff && (33'(entry.pos) == ncs_ff) && (ncs_ff < 33'(riff_ff));
   assign hdr_base  = hdr_start ? entry.pos : base_ff;
   assign hdr_rel   = entry.pos - hdr_base;
   assign body_rel  = entry.pos - base_ff;
   assign end_sum   = 33'(pos_plus1) + 33'(hs);

   // Parse step for the byte at the head of the queue.
   always_comb begin
      riff_in    = riff_ff;
      ncs_in     = ncs_ff;
      tag_in     = tag_ff;
      fmt_tag_in = fmt_tag_ff;
      chan_in    = chan_ff;
      rate_in    = rate_ff;
      bits_in    = bits_ff;
      seen_in    = seen_ff;
      dstart_in  = dstart_ff;
      dlen_in    = dlen_ff;
      err_in     = err_ff;
      in_hdr_in  = in_hdr_ff;
      base_in    = base_ff;
      if (entry.parse_en && (err_ff == rwhp_pkg::ST_OK)) begin
         priority if (entry.pos == OFFSET_BITS'(3)) begin
            if (hs != rwhp_pkg::MAGIC_RIFF) begin
               err_in = rwhp_pkg::ST_BAD_RIFF;
            end
         end else if (entry.pos == OFFSET_BITS'(7)) begin
            riff_in = hs;
         end else if (entry.pos == OFFSET_BITS'(11)) begin
            if (hs != rwhp_pkg::MAGIC_WAVE) begin
               err_in = rwhp_pkg::ST_BAD_WAVE;
            end
         end else if (entry.pos < OFFSET_BITS'(12)) begin
            err_in = err_ff;
         end else if (hdr_start || in_hdr_ff) begin
            in_hdr_in = 1'b1;
            base_in   = hdr_base;
            if (hdr_rel == OFFSET_BITS'(3)) begin
               tag_in = hs;
            end else if (hdr_rel == OFFSET_BITS'(7)) begin
               in_hdr_in = 1'b0;
               if (hs == 32'd0) begin
                  err_in = rwhp_pkg::ST_EMPTY;
               end else if ((tag_ff == rwhp_pkg::MAGIC_FMT) && (hs < 32'd16)) begin
                  err_in = rwhp_pkg::ST_SHORT_FMT;
               end else begin
                  if (tag_ff == rwhp_pkg::MAGIC_FMT) begin
                     seen_in[0] = 1'b1;
                  end else if (tag_ff == rwhp_pkg::MAGIC_DATA) begin
                     seen_in[1] = 1'b1;
                     dstart_in  = 32'(pos_plus1);
                     dlen_in    = {hs[31:3], 3'b000};
                  end
                  base_in = pos_plus1;
                  ncs_in  = end_sum;
               end
            end
         end else if ((tag_ff == rwhp_pkg::MAGIC_FMT) && (entry.pos >= base_ff) &&
                      (33'(entry.pos) < ncs_ff)) begin
            if (body_rel == OFFSET_BITS'(1)) begin
               fmt_tag_in = hs[31:16];
            end else if (body_rel == OFFSET_BITS'(3)) begin
               chan_in = hs[31:16];
            end else if (body_rel == OFFSET_BITS'(7)) begin
               rate_in = hs;
            end else if (body_rel == OFFSET_BITS'(15)) begin
               bits_in = hs[31:16];
            end
         end else begin
            // Bytes of other chunk bodies or past the walk carry nothing to latch.
            in_hdr_in = in_hdr_ff;
         end
      end
   end

   // Final status is taken from the state as it stands after this byte.
   always_comb begin
      priority if (err_in != rwhp_pkg::ST_OK) begin
         status = err_in;
      end else if (pos_final < OFFSET_BITS'(12)) begin
         status = rwhp_pkg::ST_TRUNC;
      end else if (in_hdr_in || (ncs_in < 33'(riff_in))) begin
         status = rwhp_pkg::ST_TRUNC;
      end else if (!seen_in[0]) begin
         status = rwhp_pkg::ST_NO_FMT;
      end else if (!seen_in[1]) begin
         status = rwhp_pkg::ST_NO_DATA;
      end else if (33'(pos_final) < ncs_in) begin
         status = rwhp_pkg::ST_TRUNC;
      end else if ((fmt_tag_in != 16'd1) && (fmt_tag_in != 16'd7)) begin
         status = rwhp_pkg::ST_BAD_TAG;
      end else if ((chan_in != 16'd1) && (chan_in != 16'd2)) begin
         status = rwhp_pkg::ST_BAD_CH;
      end else if ((bits_in != 16'd8) && (bits_in != 16'd16)) begin
         status = rwhp_pkg::ST_BAD_BITS;
      end else begin
         status = rwhp_pkg::ST_OK;
      end
      sample_format = (status == rwhp_pkg::ST_OK) ?
                      {chan_in == 16'd2, bits_in == 16'd16} : 2'b00;
   end

   always_comb begin
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (pop && entry.last) begin
         rsp_in.status        = status;
         rsp_in.sample_format = sample_format;
         rsp_in.sample_rate   = rate_in;
         rsp_in.data_offset   = dstart_in;
         rsp_in.data_length   = dlen_in;
         rsp_valid_in         = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (reset || (pop && entry.last)) begin
         riff_ff    <= '0;
         ncs_ff     <= 33'd12;
         tag_ff     <= '0;
         fmt_tag_ff <= '0;
         chan_ff    <= '0;
         rate_ff    <= '0;
         bits_ff    <= '0;
         seen_ff    <= '0;
         dstart_ff  <= '0;
         dlen_ff    <= '0;
         err_ff     <= rwhp_pkg::ST_OK;
         in_hdr_ff  <= 1'b0;
         base_ff    <= '0;
      end else if (pop) begin
         riff_ff    <= riff_in;
         ncs_ff     <= ncs_in;
         tag_ff     <= tag_in;
         fmt_tag_ff <= fmt_tag_in;
         chan_ff    <= chan_in;
         rate_ff    <= rate_in;
         bits_ff    <= bits_in;
         seen_ff    <= seen_in;
         dstart_ff  <= dstart_in;
         dlen_ff    <= dlen_in;
         err_ff     <= err_in;
         in_hdr_ff  <= in_hdr_in;
         base_ff    <= base_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

@@ rtl/riff_wave_header_parser_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RIFF/WAVE header parser
// Streams a RIFF/WAVE file byte by byte and reports its format on the
// final byte.
// ----------------------------------------------------------------------------
// Usage: drive one file byte per req transaction, little-endian order, with
// last_byte set on the final byte of the file. Every byte is consumed; only
// the final byte produces a rsp transaction, carrying status, sample format,
// sample rate, data offset and data length. After the final byte the parser
// is back at its reset state and the next byte starts a new file.
// Throughput is one byte per cycle: the front end accepts a byte every cycle
// while the two-entry queue has room, and the chunk walker retires one entry
// per cycle unless a final byte waits on a held result register. The final
// byte is written into the queue when accepted and retired into the result
// register, which drives rsp_valid, once it reaches the head of the queue.
// When the receiver stalls, the result register holds; non-final bytes keep
// flowing, and a further final byte waits in the queue, after which req_ready
// drops once the queue is full.
// Reset is synchronous and clears position, walk state and the queue.
// Positions are OFFSET_BITS wide; bytes from 2^OFFSET_BITS - 1 on are not parsed.
// ----------------------------------------------------------------------------
module riff_wave_header_parser_core #(
   parameter int OFFSET_BITS = rwhp_pkg::OFFSET_BITS_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  rwhp_pkg::rwhp_req_type req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output rwhp_pkg::rwhp_rsp_type rsp_data
);

   localparam int ENTRY_W = OFFSET_BITS + 34;

   logic               push_valid, push_ready;
   logic [ENTRY_W-1:0] push_data;
   logic               q_valid, q_ready;
   logic [ENTRY_W-1:0] q_data;

   rwhp_front #(.OFFSET_BITS(OFFSET_BITS)) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data)
   );

   rwhp_queue #(.WIDTH(ENTRY_W)) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (q_valid),
      .pop_ready  (q_ready),
      .pop_data   (q_data)
   );

   rwhp_back #(.OFFSET_BITS(OFFSET_BITS)) u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (q_valid),
      .pop_ready (q_ready),
      .pop_data  (q_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   // Back pressure only comes from a queue that holds something.
   a_stall_needs_queue: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> q_valid)
      else $error("input stalled with an empty queue");

   a_format_zero_on_error: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_data.status != rwhp_pkg::ST_OK)) |-> (rsp_data.sample_format == 2'b00))
      else $error("sample format set on a failed parse");

   a_status_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.status <= rwhp_pkg::ST_BAD_BITS))
      else $error("status code out of range");

   // A good file has at least the file header and one chunk header ahead of data.
   a_ok_data_offset: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_data.status == rwhp_pkg::ST_OK)) |-> (rsp_data.data_offset >= 32'd20))
      else $error("data offset too small for a good file");

endmodule
